// ===== design/smpq_pkg.sv =====
// Package for the sorted maximum priority queue.
// Holds the item types, status and mode codes, and default sizes.
// No dependencies.
package smpq_pkg;

   localparam int CapacityDef = 16;
   localparam int DataW = 32;
   localparam int FillW = 5;

   localparam logic signed [DataW-1:0] EmptyFront = -32'sd1;

   typedef enum logic [0:0] {
      MODE_INSERT = 1'b0,
      MODE_REMOVE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNDERFLOW = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   typedef struct packed {
      mode_type                  mode;
      logic signed [DataW-1:0]   value;
   } req_type;

   typedef struct packed {
      logic signed [DataW-1:0]   removed_value;
      logic signed [DataW-1:0]   front_value;
      logic                      is_empty;
      logic [FillW-1:0]          fill_count;
      status_type                status;
   } rsp_type;

endpackage

// ===== design/smpq_store.sv =====
// Entry store of the priority queue: one write port, one read port with
// registered read data. Depends on smpq_pkg.
module smpq_store
   import smpq_pkg::*;
#(
   parameter int CAPACITY = CapacityDef,
   localparam int AW = $clog2(CAPACITY)
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  logic signed [DataW-1:0] wr_data,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output logic signed [DataW-1:0] rd_data
);

   logic signed [DataW-1:0] mem_ff [CAPACITY];
   logic signed [DataW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/smpq_ctrl.sv =====
// Sequencer of the priority queue: walks the entry store one entry at a
// time with a shared signed comparator. Depends on smpq_pkg.
module smpq_ctrl
   import smpq_pkg::*;
#(
   parameter int CAPACITY = CapacityDef,
   localparam int AW = $clog2(CAPACITY),
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  req_type                 req_item,
   output logic                    req_stall,
   input  logic                    slot_free,
   output logic                    done,
   output rsp_type                 result,
   output logic                    wr_en,
   output logic [AW-1:0]           wr_addr,
   output logic signed [DataW-1:0] wr_data,
   output logic                    rd_en,
   output logic [AW-1:0]           rd_addr,
   input  logic signed [DataW-1:0] rd_data
);

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_INS_CHK   = 8'b0000_0010,
      ST_INS_CMP   = 8'b0000_0100,
      ST_REM_FIRST = 8'b0000_1000,
      ST_REM_CHK   = 8'b0001_0000,
      ST_REM_MOV   = 8'b0010_0000,
      ST_FRONT_RD  = 8'b0100_0000,
      ST_DONE      = 8'b1000_0000
   } state_type;

   localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic signed [DataW-1:0] val_ff, val_in;
   logic signed [DataW-1:0] removed_ff, removed_in;
   status_type              status_ff, status_in;
   logic [CW-1:0]           idx_dec;
   logic                    less;

   assign idx_dec = idx_ff - CW'(1);
   assign less = rd_data < val_ff;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      val_in     = val_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff[AW-1:0];
      wr_data    = val_ff;
      rd_en      = 1'b0;
      rd_addr    = idx_dec[AW-1:0];
      done       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               val_in     = req_item.value;
               removed_in = '0;
               status_in  = STATUS_OK;
               idx_in     = count_ff;
               if (req_item.mode == MODE_INSERT) begin
                  if (count_ff >= CapCount) begin
                     status_in = STATUS_OVERFLOW;
                     state_in  = ST_FRONT_RD;
                  end else begin
                     state_in = ST_INS_CHK;
                  end
               end else if (count_ff == '0) begin
                  status_in = STATUS_UNDERFLOW;
                  state_in  = ST_FRONT_RD;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  idx_in   = CW'(1);
                  state_in = ST_REM_FIRST;
               end
            end
         end
         ST_INS_CHK: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = ST_FRONT_RD;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            wr_en = 1'b1;
            if (less) begin
               wr_data  = rd_data;
               idx_in   = idx_dec;
               state_in = ST_INS_CHK;
            end else begin
               count_in = count_ff + CW'(1);
               state_in = ST_FRONT_RD;
            end
         end
         ST_REM_FIRST: begin
            removed_in = rd_data;
            state_in   = ST_REM_CHK;
         end
         ST_REM_CHK: begin
            if (idx_ff == count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = ST_FRONT_RD;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[AW-1:0];
               state_in = ST_REM_MOV;
            end
         end
         ST_REM_MOV: begin
            wr_en    = 1'b1;
            wr_addr  = idx_dec[AW-1:0];
            wr_data  = rd_data;
            idx_in   = idx_ff + CW'(1);
            state_in = ST_REM_CHK;
         end
         ST_FRONT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      result.removed_value = removed_ff;
      result.front_value   = (count_ff == '0) ? EmptyFront : rd_data;
      result.is_empty      = (count_ff == '0);
      result.fill_count    = FillW'(count_ff);
      result.status        = status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      val_ff     <= val_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CapCount)
      else $error("Entry count exceeds capacity.");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (done && status_ff == STATUS_OVERFLOW) |-> count_ff == CapCount)
      else $error("Overflow reported on a queue that is not full.");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (done && status_ff == STATUS_UNDERFLOW) |-> count_ff == '0)
      else $error("Underflow reported on a queue that is not empty.");

   a_count_steady: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> (count_ff == $past(count_ff)))
      else $error("Entry count changed outside an operation.");

endmodule

// ===== design/sorted_max_priority_queue_top.sv =====
// Top level of the sorted maximum priority queue: sequencer, entry store
// and result register. Depends on smpq_pkg, smpq_store and smpq_ctrl.
//
// The req channel carries one operation per item: insert a signed value or
// remove the highest stored value. The rsp channel returns one item per
// operation with the removed value, the new front value, an empty flag,
// the fill count and a status. Both channels use valid and stall.
// One item is worked on at a time; req_stall is high while it is in work.
// The sequencer moves stored entries one at a time through the single
// read port of the entry store and one shared comparator. A new item is
// taken the cycle after the result is registered.
// A result waits in the output register while rsp_stall is high; the next
// item still runs, and its result waits until the register is free.
// Reset empties the queue and the output register; the store is not
// cleared, as only entries below the fill count are ever used.
module sorted_max_priority_queue_top
   import smpq_pkg::*;
#(
   parameter int CAPACITY = CapacityDef
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_item,
   output logic    req_stall,
   output logic    rsp_valid,
   output rsp_type rsp_item,
   input  logic    rsp_stall
);

   localparam int AW = $clog2(CAPACITY);

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic signed [DataW-1:0] wr_data;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic signed [DataW-1:0] rd_data;
   logic                    slot_free;
   logic                    done;
   rsp_type                 result;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff;

   smpq_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   smpq_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .req_stall (req_stall),
      .slot_free (slot_free),
      .done      (done),
      .result    (result),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== dv/sorted_max_priority_queue_top_test.sv =====
// Self-checking testbench for sorted_max_priority_queue_top, the sorted max priority queue.
// Directed and random insert/remove items are checked against an in-bench queue predictor.
// Depends on smpq_pkg and the sorted_max_priority_queue_top RTL.
`timescale 1ns / 100ps

module sorted_max_priority_queue_top_test;
   import smpq_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   req_type req_item;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_item;
   logic    rsp_stall;

   req_type                 pending_reqs[$];
   rsp_type                 expected_rsps[$];
   logic signed [DataW-1:0] stored_values[$];

   int   req_idle_pct;
   int   rsp_idle_pct;
   logic req_taken;
   int   mismatch_count;
   int   result_count;
   int   overflow_count;
   int   underflow_count;

   sorted_max_priority_queue_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .rsp_stall (rsp_stall)
   );

   always #6 clock = ~clock;

   function automatic rsp_type predict_queue_op(req_type op);
      rsp_type r;
      int      pos;
      r = '0;
      r.status = STATUS_OK;
      if (op.mode == MODE_INSERT) begin
         if (stored_values.size() >= CapacityDef) begin
            r.status = STATUS_OVERFLOW;
         end else begin
            pos = 0;
            while (pos < stored_values.size() && stored_values[pos] >= op.value) pos++;
            stored_values.insert(pos, op.value);
         end
      end else if (stored_values.size() == 0) begin
         r.status = STATUS_UNDERFLOW;
      end else begin
         r.removed_value = stored_values.pop_front();
      end
      r.is_empty = (stored_values.size() == 0);
      if (r.is_empty) begin
         r.front_value = EmptyFront;
      end else begin
         r.front_value = stored_values[0];
      end
      r.fill_count = FillW'(stored_values.size());
      return r;
   endfunction

   function automatic logic signed [DataW-1:0] pick_value();
      int sel;
      sel = $urandom_range(9);
      if (sel < 4) begin
         return DataW'($urandom_range(8)) - 4;
      end else if (sel == 4) begin
         return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      end else begin
         return $urandom;
      end
   endfunction

   task automatic push_op(mode_type m, logic signed [DataW-1:0] v);
      req_type op;
      op.mode = m;
      op.value = v;
      pending_reqs.push_back(op);
   endtask

   // Fill and drain bursts walk the fill level between empty and full; a
   // share of mixed bursts adds noise.
   task automatic add_random_items(int n_items);
      int added;
      int ins_len;
      int rem_len;
      added = 0;
      while (added < n_items) begin
         ins_len = $urandom_range(20, 1);
         rem_len = $urandom_range(20, 1);
         if ($urandom_range(4) == 0) begin
            repeat (ins_len + rem_len) begin
               push_op($urandom_range(1) ? MODE_REMOVE : MODE_INSERT, pick_value());
            end
         end else begin
            repeat (ins_len) push_op(MODE_INSERT, pick_value());
            repeat (rem_len) push_op(MODE_REMOVE, $urandom);
         end
         added += ins_len + rem_len;
      end
   endtask

   task automatic wait_for_drain();
      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(predict_queue_op(req_item));
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            req_item <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (expected_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: unexpected result item %p", $realtime, rsp_item);
            end
         end else begin
            exp_rsp = expected_rsps.pop_front();
            case (exp_rsp.status)
               STATUS_OVERFLOW:  overflow_count++;
               STATUS_UNDERFLOW: underflow_count++;
               default: ;
            endcase
            if (rsp_item.removed_value !== exp_rsp.removed_value
                  || rsp_item.front_value !== exp_rsp.front_value
                  || rsp_item.is_empty !== exp_rsp.is_empty
                  || rsp_item.fill_count !== exp_rsp.fill_count
                  || rsp_item.status !== exp_rsp.status) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: result mismatch, expected %p, got %p",
                           $realtime, exp_rsp, rsp_item);
               end
            end
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      rsp_stall = 1'b0;
      req_idle_pct = 23;
      rsp_idle_pct = 64;
      mismatch_count = 0;
      result_count = 0;
      overflow_count = 0;
      underflow_count = 0;

      push_op(MODE_REMOVE, 32'sh7fff_ffff);
      push_op(MODE_INSERT, -32'sd1);
      push_op(MODE_REMOVE, 32'sh8000_0000);
      push_op(MODE_INSERT, 32'sh8000_0000);
      push_op(MODE_INSERT, 32'sh7fff_ffff);
      push_op(MODE_REMOVE, '0);
      push_op(MODE_REMOVE, -32'sd1);
      push_op(MODE_INSERT, 32'sh7fff_ffff);
      push_op(MODE_INSERT, 32'sh8000_0000);
      push_op(MODE_INSERT, -32'sd1);
      push_op(MODE_INSERT, 32'sd0);
      push_op(MODE_INSERT, -32'sd1);
      push_op(MODE_INSERT, 32'sd1);
      push_op(MODE_INSERT, 32'sd0);
      repeat (9) push_op(MODE_INSERT, $urandom);
      push_op(MODE_INSERT, 32'sh5555_aaaa);
      push_op(MODE_REMOVE, '0);
      add_random_items(160);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait_for_drain();
      req_idle_pct = 64;
      rsp_idle_pct = 23;
      add_random_items(160);
      wait_for_drain();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      add_random_items(160);
      wait_for_drain();

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (2 * CapacityDef + 10) @(posedge clock);

      $display("Checked %0d result items, %0d mismatches.", result_count, mismatch_count);
      $display("Seen %0d overflow and %0d underflow cases.", overflow_count, underflow_count);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d result items outstanding.", expected_rsps.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
design/smpq_pkg.sv
design/smpq_store.sv
design/smpq_ctrl.sv
design/sorted_max_priority_queue_top.sv
dv/sorted_max_priority_queue_top_test.sv
